/* hdl/bgl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Binary GCD / LCM package
// Shared constants and the command and status bundles that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bgl_pkg;

   localparam int DATA_WIDTH_DEFAULT = 31;

   // Datapath work for the current cycle, as requested by the controller.
   typedef struct packed {
      logic load;        // capture a new pair of operands
      logic strip_both;  // halve both operands, count the common factor of two
      logic strip_a;     // halve the first operand
      logic reduce;      // halve b, or subtract and halve
      logic scale;       // shift the common factor back, set up the divider
      logic div_step;    // one restoring division step
      logic mul_step;    // one shift-and-add multiply step
   } bgl_cmd_type;

   // Datapath conditions that steer the controller.
   typedef struct packed {
      logic any_zero;    // one of the captured operands is zero
      logic both_even;
      logic a_even;
      logic b_even;
      logic b_done;      // the subtract-and-halve step leaves b at zero
      logic count_last;  // serial step counter is on its final step
   } bgl_sts_type;

endpackage : bgl_pkg
`default_nettype wire

/* hdl/binary_gcd_lcm_unit.sv */
`default_nettype none
// When an operand is zero the command goes straight to the result beat; else the
// unit strips the common factors of two, halves a further until it is odd, runs
// the Stein loop steps, then the serial division and the serial multiplication.
// Throughput: one command at a time; the next is taken at the earliest in the cycle
// after the result beat. The receiver cannot stall.
// Reset returns the controller to idle; the result strobe is low after reset.
// ----------------------------------------------------------------------------
// Binary GCD / LCM unit
// Greatest common divisor by Stein's method and a saturating least common
// multiple, with one result beat per accepted command.
// ----------------------------------------------------------------------------
module binary_gcd_lcm_unit #(
   parameter int DATA_WIDTH = bgl_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [DATA_WIDTH-1:0]  req_first_operand,
   input  wire logic [DATA_WIDTH-1:0]  req_second_operand,
   output logic                        rsp_valid,
   output logic      [DATA_WIDTH-1:0]  rsp_divisor_out,
   output logic      [DATA_WIDTH-1:0]  rsp_multiple_out,
   output logic                        rsp_multiple_overflow
);
   import bgl_pkg::*;

   bgl_cmd_type cmd;
   bgl_sts_type sts;

   bgl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   bgl_dp #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock                 (clock),
      .cmd                   (cmd),
      .req_first_operand     (req_first_operand),
      .req_second_operand    (req_second_operand),
      .sts                   (sts),
      .rsp_divisor_out       (rsp_divisor_out),
      .rsp_multiple_out      (rsp_multiple_out),
      .rsp_multiple_overflow (rsp_multiple_overflow)
   );

   // A result beat always ends the command.
   a_done_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("unit still busy after result beat");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_multiple_overflow) |-> (rsp_multiple_out == {DATA_WIDTH{1'b1}}))
      else $error("overflowed multiple is not saturated");

   a_zero_gcd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_divisor_out == '0))
         |-> (rsp_multiple_out == '0 && !rsp_multiple_overflow))
      else $error("zero divisor with nonzero multiple");

endmodule : binary_gcd_lcm_unit
`default_nettype wire

/* hdl/bgl_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Binary GCD / LCM controller
// State machine that sequences operand capture, the Stein reduction loop,
// the serial division and the serial multiplication.
// ----------------------------------------------------------------------------
module bgl_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  bgl_pkg::bgl_sts_type     sts,
   output bgl_pkg::bgl_cmd_type     cmd,
   output logic                     busy,
   output logic                     rsp_valid
);
   import bgl_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_TWOS   = 3'd1;
   localparam logic [2:0] ST_ODDA   = 3'd2;
   localparam logic [2:0] ST_REDUCE = 3'd3;
   localparam logic [2:0] ST_SCALE  = 3'd4;
   localparam logic [2:0] ST_DIV    = 3'd5;
   localparam logic [2:0] ST_MUL    = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_TWOS;
            end
         end
         ST_TWOS: begin
            if (sts.any_zero) begin
               state_in = ST_DONE;
            end else if (sts.both_even) begin
               cmd.strip_both = 1'b1;
            end else begin
               state_in = ST_ODDA;
            end
         end
         ST_ODDA: begin
            if (sts.a_even) begin
               cmd.strip_a = 1'b1;
            end else begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            if (!sts.b_even && sts.b_done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.count_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (sts.count_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule : bgl_ctrl
`default_nettype wire

/* hdl/bgl_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Binary GCD / LCM datapath
// Operand registers with an absolute-difference unit for the Stein loop, a
// restoring bit-serial divider for a / gcd and a saturating bit-serial
// multiplier for the quotient times b.
// ----------------------------------------------------------------------------
module bgl_dp #(
   parameter int DATA_WIDTH = bgl_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  bgl_pkg::bgl_cmd_type        cmd,
   input  wire logic [DATA_WIDTH-1:0]  req_first_operand,
   input  wire logic [DATA_WIDTH-1:0]  req_second_operand,
   output bgl_pkg::bgl_sts_type        sts,
   output logic      [DATA_WIDTH-1:0]  rsp_divisor_out,
   output logic      [DATA_WIDTH-1:0]  rsp_multiple_out,
   output logic                        rsp_multiple_overflow
);
   import bgl_pkg::*;

   localparam int CNT_WIDTH = $clog2(DATA_WIDTH);
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(DATA_WIDTH - 1);
   localparam logic [DATA_WIDTH+1:0] VALUE_MAX = {2'b00, {DATA_WIDTH{1'b1}}};

   logic [DATA_WIDTH-1:0] op_a_ff, op_a_in;
   logic [DATA_WIDTH-1:0] op_b_ff, op_b_in;
   logic [DATA_WIDTH-1:0] a_ff, a_in;
   logic [DATA_WIDTH-1:0] b_ff, b_in;
   logic [CNT_WIDTH-1:0]  shift_ff, shift_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] gcd_ff, gcd_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic                  ovf_ff, ovf_in;

   logic                  a_le_b;
   logic [DATA_WIDTH-1:0] diff;
   logic [DATA_WIDTH-1:0] b_half_diff;
   logic [DATA_WIDTH:0]   rem_shift;
   logic                  rem_ge;
   logic [DATA_WIDTH-1:0] rem_sub;
   logic [DATA_WIDTH+1:0] prod;

   assign a_le_b      = (a_ff <= b_ff);
   assign diff        = a_le_b ? (b_ff - a_ff) : (a_ff - b_ff);
   assign b_half_diff = diff >> 1;

   assign rem_shift = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign rem_ge    = (rem_shift >= {1'b0, gcd_ff});
   // When the step restores nothing the difference is below the divisor,
   // so the low bits hold it exactly.
   assign rem_sub   = rem_shift[DATA_WIDTH-1:0] - gcd_ff;

   // Multiply from the quotient's top bit down; any partial sum above the
   // field maximum makes the final product overflow too.
   assign prod = {1'b0, acc_ff, 1'b0}
               + (quo_ff[DATA_WIDTH-1] ? {2'b00, op_b_ff} : '0);

   always_comb begin
      op_a_in  = op_a_ff;
      op_b_in  = op_b_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      gcd_in   = gcd_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;

      if (cmd.load) begin
         op_a_in  = req_first_operand;
         op_b_in  = req_second_operand;
         a_in     = req_first_operand;
         b_in     = req_second_operand;
         shift_in = '0;
         cnt_in   = '0;
         gcd_in   = req_first_operand | req_second_operand;
         acc_in   = '0;
         ovf_in   = 1'b0;
      end

      if (cmd.strip_both) begin
         a_in     = a_ff >> 1;
         b_in     = b_ff >> 1;
         shift_in = shift_ff + CNT_WIDTH'(1);
      end

      if (cmd.strip_a) begin
         a_in = a_ff >> 1;
      end

      if (cmd.reduce) begin
         if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else begin
            if (!a_le_b) begin
               a_in = b_ff;
            end
            b_in = b_half_diff;
         end
      end

      if (cmd.scale) begin
         gcd_in = a_ff << shift_ff;
         rem_in = '0;
         quo_in = op_a_ff;
         cnt_in = '0;
      end

      if (cmd.div_step) begin
         if (rem_ge) begin
            rem_in = rem_sub;
         end else begin
            rem_in = rem_shift[DATA_WIDTH-1:0];
         end
         quo_in = {quo_ff[DATA_WIDTH-2:0], rem_ge};
         cnt_in = (cnt_ff == CNT_LAST) ? '0 : cnt_ff + CNT_WIDTH'(1);
      end

      if (cmd.mul_step) begin
         if (!ovf_ff) begin
            if (prod > VALUE_MAX) begin
               ovf_in = 1'b1;
            end else begin
               acc_in = prod[DATA_WIDTH-1:0];
            end
         end
         quo_in = quo_ff << 1;
         cnt_in = (cnt_ff == CNT_LAST) ? '0 : cnt_ff + CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      op_a_ff  <= op_a_in;
      op_b_ff  <= op_b_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      shift_ff <= shift_in;
      cnt_ff   <= cnt_in;
      gcd_ff   <= gcd_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      acc_ff   <= acc_in;
      ovf_ff   <= ovf_in;
   end

   assign sts.any_zero   = (op_a_ff == '0) || (op_b_ff == '0);
   assign sts.both_even  = !a_ff[0] && !b_ff[0];
   assign sts.a_even     = !a_ff[0];
   assign sts.b_even     = !b_ff[0];
   assign sts.b_done     = (b_half_diff == '0);
   assign sts.count_last = (cnt_ff == CNT_LAST);

   assign rsp_divisor_out       = gcd_ff;
   assign rsp_multiple_out      = ovf_ff ? {DATA_WIDTH{1'b1}} : acc_ff;
   assign rsp_multiple_overflow = ovf_ff;

endmodule : bgl_dp
`default_nettype wire
